// ----- design/wino_pkg.sv -----
// Package: widths, types and saturation helpers for the Winograd tile unit.
`timescale 1ns / 1ps
package wino_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int ACCUM_BITS  = 48;
  localparam int LANES       = 16;
  localparam int TV_BITS     = SAMPLE_BITS + 3;
  localparam int TU_BITS     = SAMPLE_BITS + 5;
  localparam int OUT_BITS    = 48;

  localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACCUM_BITS-1:0]  acc_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  function automatic acc_t sat_acc(input logic signed [ACCUM_BITS+1:0] x);
    if (x > $signed({{2{ACC_MAX[ACCUM_BITS-1]}}, ACC_MAX})) return ACC_MAX;
    if (x < $signed({{2{ACC_MIN[ACCUM_BITS-1]}}, ACC_MIN})) return ACC_MIN;
    return x[ACCUM_BITS-1:0];
  endfunction
endpackage

// ----- design/wino_lane.sv -----
// Lane: one element product U*V, saturated, accumulated into its accumulator.
`timescale 1ns / 1ps
module wino_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 mac_en,
  input  logic                                 clr,
  input  logic signed [wino_pkg::TU_BITS-1:0]  u,
  input  logic signed [wino_pkg::TV_BITS-1:0]  v,
  output wino_pkg::acc_t                       acc
);
  import wino_pkg::*;
  localparam int P_BITS = TU_BITS + TV_BITS;
  localparam int X_BITS = (P_BITS > ACCUM_BITS + 2) ? P_BITS : ACCUM_BITS + 2;
  logic signed [P_BITS-1:0] prod;
  logic signed [X_BITS-1:0] prod_w;
  logic signed [ACCUM_BITS+1:0] prod_x, sum;
  acc_t acc_r, acc_nxt, psat;

  assign prod = u * v;
  always_comb begin
    prod_w = X_BITS'(prod);
    if (prod_w > X_BITS'(ACC_MAX)) psat = ACC_MAX;
    else if (prod_w < X_BITS'(ACC_MIN)) psat = ACC_MIN;
    else psat = prod_w[ACCUM_BITS-1:0];
    prod_x = {{2{psat[ACCUM_BITS-1]}}, psat};
    sum = {{2{acc_r[ACCUM_BITS-1]}}, acc_r} + prod_x;
    acc_nxt = acc_r;
    if (clr) acc_nxt = '0;
    else if (mac_en) acc_nxt = sat_acc(sum);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else acc_r <= acc_nxt;
  end
  assign acc = acc_r;
endmodule

// ----- design/wino_merge.sv -----
// Merge: output transform A^T M A over the 16 accumulators, shift and saturate.
`timescale 1ns / 1ps
module wino_merge (
  input  wino_pkg::acc_t  m [16],
  input  logic [1:0]      pix,
  output wino_pkg::acc_t  q
);
  import wino_pkg::*;
  localparam int W = ACCUM_BITS + 4;
  logic signed [W-1:0] p [4];
  logic signed [W-1:0] y, s;
  logic r;
  always_comb begin
    r = pix[1];
    for (int c = 0; c < 4; c++) begin
      if (!r) p[c] = W'(m[c]) + W'(m[4+c]) + W'(m[8+c]);
      else    p[c] = W'(m[4+c]) - W'(m[8+c]) - W'(m[12+c]);
    end
    if (!pix[0]) y = p[0] + p[1] + p[2];
    else         y = p[1] - p[2] - p[3];
    s = y >>> 2;
    if (s > W'(ACC_MAX)) q = ACC_MAX;
    else if (s < W'(ACC_MIN)) q = ACC_MIN;
    else q = s[ACCUM_BITS-1:0];
  end
endmodule

// ----- design/winograd_f2x2_3x3_tile_unit.sv -----
// Top level: row buffers, input/filter transforms, 16 MAC lanes, output sequencer.
//  channel | ports                                            | handshake
//  input   | in_data_*, in_tap_*, in_row_index, in_final_channel | start & !busy
//  result  | out_pixel_*, out_tile_done                       | out_valid, no stall
// Rows 0..2 are stored in the row buffers. Row 3 is transformed with the buffered rows into
// registers, then the 16 lanes accumulate; busy is high during the lane and output steps. On
// a final channel, the four pixels are then emitted in turn from the output transform. Reset clears
// accumulators and control; row buffers are undefined until written. The receiver cannot stall.
`timescale 1ns / 1ps
module winograd_f2x2_3x3_tile_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  wino_pkg::sample_t     in_data_0,
  input  wino_pkg::sample_t     in_data_1,
  input  wino_pkg::sample_t     in_data_2,
  input  wino_pkg::sample_t     in_data_3,
  input  wino_pkg::sample_t     in_tap_0,
  input  wino_pkg::sample_t     in_tap_1,
  input  wino_pkg::sample_t     in_tap_2,
  input  logic [1:0]            in_row_index,
  input  logic                  in_final_channel,
  output logic                  out_valid,
  output logic signed [wino_pkg::OUT_BITS-1:0] out_pixel_value,
  output logic                  out_pixel_col,
  output logic                  out_pixel_row,
  output logic                  out_tile_done
);
  import wino_pkg::*;
  sample_t d_r [12];
  sample_t g_r [9];
  logic signed [TV_BITS-1:0] v_r [16];
  logic signed [TU_BITS-1:0] u_r [16];
  logic signed [TV_BITS-1:0] t [4][4], vv [4][4];
  logic signed [TU_BITS-1:0] tg [4][3], uu [4][4];
  logic signed [TV_BITS-1:0] dd [4][4];
  logic signed [TU_BITS-1:0] gg [3][3];
  state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  logic [1:0] pix_r, pix_nxt;
  logic [1:0] rows_r;
  logic [3:0] d_base, g_base;
  acc_t m [16];
  acc_t q;
  logic take, clr;

  assign take = start && !busy;
  assign busy = state_r != ST_IDLE;
  assign d_base = {in_row_index, 2'b00};
  assign g_base = {2'b00, in_row_index} * 4'd3;

  always_ff @(posedge clk) begin
    if (take && in_row_index != 2'd3) begin
      d_r[d_base]        <= in_data_0;
      d_r[d_base + 4'd1] <= in_data_1;
      d_r[d_base + 4'd2] <= in_data_2;
      d_r[d_base + 4'd3] <= in_data_3;
      g_r[g_base]        <= in_tap_0;
      g_r[g_base + 4'd1] <= in_tap_1;
      g_r[g_base + 4'd2] <= in_tap_2;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) dd[r][c] = TV_BITS'(d_r[r*4+c]);
    end
    dd[3][0] = TV_BITS'(in_data_0);
    dd[3][1] = TV_BITS'(in_data_1);
    dd[3][2] = TV_BITS'(in_data_2);
    dd[3][3] = TV_BITS'(in_data_3);
    for (int c = 0; c < 4; c++) begin
      t[0][c] = dd[0][c] - dd[2][c];
      t[1][c] = dd[1][c] + dd[2][c];
      t[2][c] = dd[2][c] - dd[1][c];
      t[3][c] = dd[1][c] - dd[3][c];
    end
    for (int r = 0; r < 4; r++) begin
      vv[r][0] = t[r][0] - t[r][2];
      vv[r][1] = t[r][1] + t[r][2];
      vv[r][2] = t[r][2] - t[r][1];
      vv[r][3] = t[r][1] - t[r][3];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) gg[r][c] = TU_BITS'(g_r[r*3+c]);
    end
    for (int c = 0; c < 3; c++) begin
      tg[0][c] = gg[0][c] <<< 1;
      tg[1][c] = gg[0][c] + gg[1][c] + gg[2][c];
      tg[2][c] = gg[0][c] - gg[1][c] + gg[2][c];
      tg[3][c] = gg[2][c] <<< 1;
    end
    for (int r = 0; r < 4; r++) begin
      uu[r][0] = tg[r][0] <<< 1;
      uu[r][1] = tg[r][0] + tg[r][1] + tg[r][2];
      uu[r][2] = tg[r][0] - tg[r][1] + tg[r][2];
      uu[r][3] = tg[r][2] <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_row_index == 2'd3) begin
      for (int i = 0; i < 16; i++) begin
        v_r[i] <= vv[i/4][i%4];
        u_r[i] <= uu[i/4][i%4];
      end
    end
  end

  assign clr = (state_r == ST_OUT) && (pix_r == 2'd3);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    wino_lane u_lane (
      .clk(clk), .rst_n(rst_n), .mac_en(state_r == ST_MAC), .clr(clr),
      .u(u_r[i]), .v(v_r[i]), .acc(m[i])
    );
  end

  wino_merge u_merge (.m(m), .pix(pix_r), .q(q));

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    pix_nxt = pix_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_row_index == 2'd3) begin
          state_nxt = ST_MAC;
          fin_nxt = in_final_channel;
        end
      end
      ST_MAC: begin
        pix_nxt = 2'd0;
        state_nxt = fin_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        pix_nxt = pix_r + 2'd1;
        if (pix_r == 2'd3) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r <= 1'b0;
      pix_r <= 2'd0;
      rows_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      pix_r <= pix_nxt;
      if (take) rows_r <= in_row_index + 2'd1;
    end
  end

  assign out_valid = state_r == ST_OUT;
  assign out_pixel_value = OUT_BITS'(q);
  assign out_pixel_col = pix_r[0];
  assign out_pixel_row = pix_r[1];
  assign out_tile_done = out_valid && pix_r == 2'd3;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_mac_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |=> state_r != ST_MAC) else $error("mac twice");
  a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> pix_r == 2'd0) else $error("pixel order");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tile_done |=> state_r == ST_IDLE) else $error("no idle after tile");
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> rows_r == 2'd0) else $error("rows count");
endmodule
